// ===== rtl/core/lfsa_pkg.sv =====
// ----------------------------------------------------------------------------
// Lowest free slot allocator package
// Shared types, status codes and cell geometry for the allocator.
// ----------------------------------------------------------------------------
package lfsa_pkg;

   // Slot numbers, pool sizes and free counts all fit in nine bits.
   localparam int SLOT_W = 9;
   typedef logic [SLOT_W-1:0] slot_type;

   // Each cell of the chain owns this many bitmap entries.
   localparam int CELL_BITS = 64;
   localparam int CELL_LOG  = $clog2(CELL_BITS);
   typedef logic [CELL_LOG-1:0] bit_index_type;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [2:0] ST_OK            = 3'd0;
   localparam logic [2:0] ST_NO_SPACE      = 3'd1;
   localparam logic [2:0] ST_WRONG_POOL    = 3'd2;
   localparam logic [2:0] ST_NOT_ALLOCATED = 3'd3;
   localparam logic [2:0] ST_OUT_OF_RANGE  = 3'd4;

   localparam logic REG_SLOT_COUNT = 1'b0;
   localparam logic REG_POOL_ID    = 1'b1;

   // Request token that walks down the chain of cells.
   typedef struct packed {
      logic       valid;
      logic       alloc;
      logic       free_op;
      slot_type   slot;
      logic       hit;
      logic [2:0] status;
   } token_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] granted;
      slot_type   left;
   } result_type;

endpackage

// ===== rtl/core/lfsa_cell.sv =====
// ----------------------------------------------------------------------------
// Allocator bitmap cell
// Holds one segment of the allocation bitmap and services the request token
// as it passes, then hands the token on to the next cell.
// ----------------------------------------------------------------------------
module lfsa_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 clear,
   input  lfsa_pkg::slot_type   pool_size,
   input  lfsa_pkg::token_type  tok_in,
   output lfsa_pkg::token_type  tok_out_ff
);

   localparam int BASE = CELL_INDEX * lfsa_pkg::CELL_BITS;

   logic [lfsa_pkg::CELL_BITS-1:0] taken_ff;
   logic [lfsa_pkg::CELL_BITS-1:0] taken_in;
   logic [lfsa_pkg::CELL_BITS-1:0] avail;
   lfsa_pkg::token_type            tok_out_in;
   lfsa_pkg::bit_index_type        first_free;
   lfsa_pkg::bit_index_type        local_bit;
   logic                           any_free;
   logic                           mine;

   always_comb begin
      for (int j = 0; j < lfsa_pkg::CELL_BITS; j++) begin
         avail[j] = !taken_ff[j] && ((BASE + j) < int'(pool_size));
      end
      any_free   = |avail;
      first_free = '0;
      // Scan downward so the lowest free entry wins.
      for (int j = lfsa_pkg::CELL_BITS - 1; j >= 0; j--) begin
         if (avail[j]) begin
            first_free = lfsa_pkg::bit_index_type'(j);
         end
      end
      local_bit = tok_in.slot[lfsa_pkg::CELL_LOG-1:0];
      mine = int'(tok_in.slot[lfsa_pkg::SLOT_W-1:lfsa_pkg::CELL_LOG]) == CELL_INDEX;

      taken_in   = taken_ff;
      tok_out_in = tok_in;
      if (tok_in.valid && tok_in.alloc && !tok_in.hit && any_free) begin
         taken_in[first_free] = 1'b1;
         tok_out_in.hit  = 1'b1;
         tok_out_in.slot = lfsa_pkg::slot_type'(BASE + int'(first_free));
      end else if (tok_in.valid && tok_in.free_op && tok_in.status == lfsa_pkg::ST_OK
                   && mine && taken_ff[local_bit]) begin
         taken_in[local_bit] = 1'b0;
         tok_out_in.hit = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         taken_ff <= '0;
      end else begin
         taken_ff <= taken_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_out_ff.valid <= 1'b0;
      end else begin
         tok_out_ff.valid <= tok_in.valid;
      end
      tok_out_ff.alloc   <= tok_out_in.alloc;
      tok_out_ff.free_op <= tok_out_in.free_op;
      tok_out_ff.slot    <= tok_out_in.slot;
      tok_out_ff.hit     <= tok_out_in.hit;
      tok_out_ff.status  <= tok_out_in.status;
   end

endmodule

// ===== rtl/core/lowest_free_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// Lowest free slot allocator
// Hands out the lowest free slot of a pool and takes slots back with checks.
// ----------------------------------------------------------------------------
// One request is in flight at a time. A request enters a chain of bitmap
// cells, each owning 64 slots, and moves one cell per cycle; its result is
// registered after the last cell. A new request is accepted once the
// previous result has reached the output register, so a stalled output
// holds off the next request. Writing slot_count empties the pool at once;
// writing pool_id leaves the slots as they are.
// ----------------------------------------------------------------------------
module lowest_free_slot_allocator #(
   parameter int NUM_SLOTS = 256
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [7:0]  req_free_slot,
   input  logic [31:0] req_free_pool,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_granted_slot,
   output logic [8:0]  rsp_free_left,

   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int NUM_CELLS  = (NUM_SLOTS + lfsa_pkg::CELL_BITS - 1) / lfsa_pkg::CELL_BITS;
   localparam int RESET_SIZE = (256 < NUM_SLOTS) ? 256 : NUM_SLOTS;

   lfsa_pkg::slot_type   pool_size_ff;
   lfsa_pkg::slot_type   pool_size_in;
   logic [31:0]          pool_id_ff;
   lfsa_pkg::slot_type   taken_total_ff;
   lfsa_pkg::slot_type   taken_total_in;
   logic                 busy_ff;
   logic                 busy_in;
   logic                 hold_valid_ff;
   logic                 hold_valid_in;
   lfsa_pkg::result_type hold_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   lfsa_pkg::result_type rsp_ff;
   lfsa_pkg::result_type rsp_in;
   lfsa_pkg::token_type  entry_ff;
   lfsa_pkg::token_type  entry_in;
   lfsa_pkg::token_type  chain [NUM_CELLS+1];
   lfsa_pkg::token_type  tok_exit;
   lfsa_pkg::result_type result;
   lfsa_pkg::slot_type   wr_count;
   logic                 accept;
   logic                 clear_pool;
   logic                 rsp_free;

   assign accept     = req_valid && !busy_ff;
   assign clear_pool = csr_write && csr_index == lfsa_pkg::REG_SLOT_COUNT;
   assign wr_count   = csr_wdata[lfsa_pkg::SLOT_W-1:0];
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // Pool size is stored already clamped to the bitmap depth.
   always_comb begin
      pool_size_in = pool_size_ff;
      if (clear_pool) begin
         if (int'(wr_count) < NUM_SLOTS) begin
            pool_size_in = wr_count;
         end else begin
            pool_size_in = lfsa_pkg::slot_type'(NUM_SLOTS);
         end
      end
   end

   // Pool and range checks happen before the token enters the chain.
   always_comb begin
      entry_in.valid   = accept;
      entry_in.alloc   = req_operation == lfsa_pkg::OP_ALLOC;
      entry_in.free_op = req_operation == lfsa_pkg::OP_FREE;
      entry_in.slot    = {1'b0, req_free_slot};
      entry_in.hit     = 1'b0;
      entry_in.status  = lfsa_pkg::ST_OK;
      if (req_operation == lfsa_pkg::OP_FREE) begin
         priority if (req_free_pool != pool_id_ff) begin
            entry_in.status = lfsa_pkg::ST_WRONG_POOL;
         end else if ({1'b0, req_free_slot} >= pool_size_ff) begin
            entry_in.status = lfsa_pkg::ST_OUT_OF_RANGE;
         end else begin
            entry_in.status = lfsa_pkg::ST_OK;
         end
      end
   end

   assign chain[0] = entry_ff;

   for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
      lfsa_cell #(
         .CELL_INDEX(k)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .clear      (clear_pool),
         .pool_size  (pool_size_ff),
         .tok_in     (chain[k]),
         .tok_out_ff (chain[k+1])
      );
   end

   assign tok_exit = chain[NUM_CELLS];

   always_comb begin
      taken_total_in = taken_total_ff;
      result.status  = tok_exit.status;
      result.granted = '0;
      if (tok_exit.alloc) begin
         if (tok_exit.hit) begin
            taken_total_in = taken_total_ff + 1'b1;
            result.granted = tok_exit.slot[7:0];
         end else begin
            result.status = lfsa_pkg::ST_NO_SPACE;
         end
      end else if (tok_exit.status == lfsa_pkg::ST_OK) begin
         if (tok_exit.hit) begin
            taken_total_in = taken_total_ff - 1'b1;
         end else begin
            result.status = lfsa_pkg::ST_NOT_ALLOCATED;
         end
      end
      if (!tok_exit.valid) begin
         taken_total_in = taken_total_ff;
      end
      if (clear_pool) begin
         taken_total_in = '0;
      end
      result.left = pool_size_ff - taken_total_in;
   end

   // A finished result goes straight to the output register when it is free,
   // otherwise it parks in the hold register and the block stays busy.
   always_comb begin
      busy_in       = busy_ff;
      hold_valid_in = hold_valid_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         busy_in = 1'b1;
      end
      if (tok_exit.valid) begin
         if (rsp_free) begin
            rsp_in       = result;
            rsp_valid_in = 1'b1;
            busy_in      = 1'b0;
         end else begin
            hold_valid_in = 1'b1;
         end
      end else if (hold_valid_ff && rsp_free) begin
         rsp_in        = hold_ff;
         rsp_valid_in  = 1'b1;
         hold_valid_in = 1'b0;
         busy_in       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_size_ff   <= lfsa_pkg::slot_type'(RESET_SIZE);
         pool_id_ff     <= '0;
         taken_total_ff <= '0;
         busy_ff        <= 1'b0;
         hold_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         entry_ff.valid <= 1'b0;
      end else begin
         pool_size_ff   <= pool_size_in;
         if (csr_write && csr_index == lfsa_pkg::REG_POOL_ID) begin
            pool_id_ff <= csr_wdata;
         end
         taken_total_ff <= taken_total_in;
         busy_ff        <= busy_in;
         hold_valid_ff  <= hold_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         entry_ff.valid <= entry_in.valid;
      end
      entry_ff.alloc   <= entry_in.alloc;
      entry_ff.free_op <= entry_in.free_op;
      entry_ff.slot    <= entry_in.slot;
      entry_ff.hit     <= entry_in.hit;
      entry_ff.status  <= entry_in.status;
      rsp_ff           <= rsp_in;
      if (tok_exit.valid && !rsp_free) begin
         hold_ff <= result;
      end
   end

   assign req_stall        = busy_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_ff.status;
   assign rsp_granted_slot = rsp_ff.granted;
   assign rsp_free_left    = rsp_ff.left;

endmodule

// ===== rtl/core/lfsa_checker.sv =====
// ----------------------------------------------------------------------------
// Lowest free slot allocator checker
// Port-level assertions on the allocator, attached to the top level by bind.
// ----------------------------------------------------------------------------
module lfsa_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_status,
   input logic [7:0] rsp_granted_slot,
   input logic [8:0] rsp_free_left
);

   // A stalled result must stay put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_granted_slot) && $stable(rsp_free_left))
      else $error("stalled result changed");

   // Only one request is in flight, so an accepted request blocks the next.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request accepted while one is in flight");

   a_granted_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != lfsa_pkg::ST_OK |-> rsp_granted_slot == 8'd0)
      else $error("failed request reports a granted slot");

   a_no_space_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == lfsa_pkg::ST_NO_SPACE |-> rsp_free_left == 9'd0)
      else $error("no space reported while slots remain free");

endmodule

bind lowest_free_slot_allocator lfsa_checker u_lfsa_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_status       (rsp_status),
   .rsp_granted_slot (rsp_granted_slot),
   .rsp_free_left    (rsp_free_left)
);

// ===== bench/slot_pool_scoreboard_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot pool scoreboard
// Tracks the allocation bitmap of the pool, predicts the answer to every
// accepted request and compares the answers that come back from the block.
// ----------------------------------------------------------------------------
package slot_pool_scoreboard_pkg;

   localparam int POOL_SLOTS = 256;

   class slot_pool_scoreboard;
      bit [POOL_SLOTS-1:0]  taken_map;
      int                   taken_total;
      logic [8:0]           slot_count;
      logic [31:0]          owner_id;
      lfsa_pkg::result_type owed_responses[$];
      int                   mismatches;

      function new();
         slot_count  = 9'd256;
         owner_id    = 32'd0;
         taken_map   = '0;
         taken_total = 0;
         mismatches  = 0;
      endfunction

      function int pool_size();
         return (slot_count > POOL_SLOTS) ? POOL_SLOTS : int'(slot_count);
      endfunction

      function int pending();
         return owed_responses.size();
      endfunction

      // A new pool size empties the pool; a new owner keeps the slots.
      function void write_register(logic index, logic [31:0] value);
         if (index == lfsa_pkg::REG_SLOT_COUNT) begin
            slot_count  = value[8:0];
            taken_map   = '0;
            taken_total = 0;
         end else begin
            owner_id = value;
         end
      endfunction

      function int random_taken_slot();
         int total;
         int k;
         total = 0;
         for (int i = 0; i < POOL_SLOTS; i++) if (taken_map[i]) total++;
         if (total == 0) return -1;
         k = $urandom_range(0, total - 1);
         for (int i = 0; i < POOL_SLOTS; i++) begin
            if (taken_map[i]) begin
               if (k == 0) return i;
               k--;
            end
         end
         return -1;
      endfunction

      function void apply_request(logic op, logic [7:0] slot, logic [31:0] pool);
         lfsa_pkg::result_type answer;
         int size;
         int lowest;
         size = pool_size();
         answer.status  = lfsa_pkg::ST_OK;
         answer.granted = 8'd0;
         if (op == lfsa_pkg::OP_ALLOC) begin
            lowest = -1;
            for (int i = size - 1; i >= 0; i--) if (!taken_map[i]) lowest = i;
            if (lowest < 0) begin
               answer.status = lfsa_pkg::ST_NO_SPACE;
            end else begin
               taken_map[lowest] = 1'b1;
               taken_total++;
               answer.granted = lowest[7:0];
            end
         end else if (pool != owner_id) begin
            answer.status = lfsa_pkg::ST_WRONG_POOL;
         end else if (int'(slot) >= size) begin
            answer.status = lfsa_pkg::ST_OUT_OF_RANGE;
         end else if (!taken_map[slot]) begin
            answer.status = lfsa_pkg::ST_NOT_ALLOCATED;
         end else begin
            taken_map[slot] = 1'b0;
            if (taken_total > 0) taken_total--;
         end
         answer.left = (size > taken_total) ? 9'(size - taken_total) : 9'd0;
         owed_responses.push_back(answer);
      endfunction

      task report_mismatch(string what, int got, int want);
         $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
         mismatches++;
      endtask

      task check_response(logic [2:0] status, logic [7:0] granted, logic [8:0] left);
         lfsa_pkg::result_type want;
         if (owed_responses.size() == 0) begin
            report_mismatch("response without request", int'(status), -1);
         end else begin
            want = owed_responses.pop_front();
            if (status !== want.status)
               report_mismatch("status", int'(status), int'(want.status));
            if (granted !== want.granted)
               report_mismatch("granted_slot", int'(granted), int'(want.granted));
            if (left !== want.left)
               report_mismatch("free_left", int'(left), int'(want.left));
         end
      endtask
   endclass

endpackage

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lowest free slot allocator testbench
// Drives allocate and free requests, mostly under random idling on both channels,
// changes pool size and owner between phases, and checks every response.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int STALL_LIMIT = 4000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_operation = lfsa_pkg::OP_ALLOC;
   logic [7:0]  req_free_slot = 8'd0;
   logic [31:0] req_free_pool = 32'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_granted_slot;
   logic [8:0]  rsp_free_left;
   logic        csr_write = 1'b0;
   logic        csr_index = lfsa_pkg::REG_SLOT_COUNT;
   logic [31:0] csr_wdata = 32'd0;

   bit                                            quiet = 1'b0;
   int                                            idle_cycles = 0;
   slot_pool_scoreboard_pkg::slot_pool_scoreboard sb = new();

   lowest_free_slot_allocator #(.NUM_SLOTS(slot_pool_scoreboard_pkg::POOL_SLOTS)) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_free_slot   (req_free_slot),
      .req_free_pool   (req_free_pool),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_granted_slot(rsp_granted_slot),
      .rsp_free_left   (rsp_free_left),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(0, 99) < 26);
   end

   // Response checking and the watchdog share the sampling edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            sb.check_response(rsp_status, rsp_granted_slot, rsp_free_left);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   task automatic send_request(input logic op, input logic [7:0] slot, input logic [31:0] pool);
      @(negedge clock);
      while (!quiet && $urandom_range(0, 99) < 26) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_free_slot <= slot;
      req_free_pool <= pool;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.apply_request(op, slot, pool);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic index, input logic [31:0] value);
      drain();
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      sb.write_register(index, value);
   endtask

   task automatic run_phase(input logic [31:0] count_word, input logic [31:0] owner,
                            input int items, input int alloc_pct);
      write_reg(lfsa_pkg::REG_SLOT_COUNT, count_word);
      write_reg(lfsa_pkg::REG_POOL_ID, owner);
      for (int n = 0; n < items; n++) begin
         logic        op;
         logic [7:0]  slot;
         logic [31:0] pool;
         int          pick;
         int          roll;
         slot = 8'($urandom);
         pool = $urandom;
         op   = lfsa_pkg::OP_FREE;
         if ($urandom_range(0, 99) < alloc_pct) begin
            op = lfsa_pkg::OP_ALLOC;
         end else begin
            pick = sb.random_taken_slot();
            roll = $urandom_range(0, 99);
            // Mostly frees of slots that are really held; the rest probe the checks.
            if (roll < 75 && pick >= 0) begin
               slot = pick[7:0];
               pool = sb.owner_id;
            end else if (roll < 85) begin
               if (sb.pool_size() > 0) slot = 8'($urandom_range(0, sb.pool_size() - 1));
               pool = sb.owner_id;
            end else if (roll < 89) begin
               pool = sb.owner_id;
            end else if (roll < 96) begin
               pool = sb.owner_id ^ (32'd1 << $urandom_range(0, 31));
            end
         end
         send_request(op, slot, pool);
      end
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Lowest-first order, double free and a foreign owner at the reset setup.
      send_request(lfsa_pkg::OP_ALLOC, 8'hFF, 32'hFFFF_FFFF);
      send_request(lfsa_pkg::OP_ALLOC, 8'h00, 32'h0000_0000);
      send_request(lfsa_pkg::OP_FREE, 8'd0, 32'd0);
      send_request(lfsa_pkg::OP_FREE, 8'd0, 32'd0);
      send_request(lfsa_pkg::OP_ALLOC, 8'd0, 32'd0);
      send_request(lfsa_pkg::OP_FREE, 8'd255, 32'd0);
      send_request(lfsa_pkg::OP_FREE, 8'd1, 32'hFFFF_FFFF);

      // A new owner keeps the slots already handed out.
      write_reg(lfsa_pkg::REG_POOL_ID, 32'hFFFF_FFFF);
      send_request(lfsa_pkg::OP_FREE, 8'd1, 32'hFFFF_FFFF);
      send_request(lfsa_pkg::OP_FREE, 8'd0, 32'd0);

      // Single slot pool.
      write_reg(lfsa_pkg::REG_SLOT_COUNT, 32'd1);
      send_request(lfsa_pkg::OP_ALLOC, 8'd0, 32'd0);
      send_request(lfsa_pkg::OP_ALLOC, 8'd0, 32'd0);
      send_request(lfsa_pkg::OP_FREE, 8'd1, 32'hFFFF_FFFF);
      send_request(lfsa_pkg::OP_FREE, 8'd0, 32'd0);
      send_request(lfsa_pkg::OP_FREE, 8'd0, 32'hFFFF_FFFF);

      // Empty pool: wrong owner is reported ahead of out of range.
      write_reg(lfsa_pkg::REG_SLOT_COUNT, 32'd0);
      send_request(lfsa_pkg::OP_ALLOC, 8'd0, 32'd0);
      send_request(lfsa_pkg::OP_FREE, 8'd0, 32'hFFFF_FFFF);
      send_request(lfsa_pkg::OP_FREE, 8'd0, 32'h7FFF_FFFF);

      // Oversized count acts as the full pool, and a resize empties it.
      write_reg(lfsa_pkg::REG_SLOT_COUNT, 32'd511);
      write_reg(lfsa_pkg::REG_POOL_ID, 32'd0);
      send_request(lfsa_pkg::OP_ALLOC, 8'd0, 32'd0);
      send_request(lfsa_pkg::OP_ALLOC, 8'd0, 32'd0);
      send_request(lfsa_pkg::OP_FREE, 8'd255, 32'd0);
      write_reg(lfsa_pkg::REG_SLOT_COUNT, 32'd2);
      send_request(lfsa_pkg::OP_ALLOC, 8'd0, 32'd0);
      send_request(lfsa_pkg::OP_ALLOC, 8'd0, 32'd0);
      send_request(lfsa_pkg::OP_ALLOC, 8'd0, 32'd0);
      send_request(lfsa_pkg::OP_FREE, 8'd2, 32'd0);

      run_phase(32'd256, $urandom, 300, 95);
      quiet = 1'b1;
      run_phase(32'd64, 32'd0, 100, 50);
      quiet = 1'b0;
      run_phase(32'd1, 32'hFFFF_FFFF, 40, 50);
      run_phase(32'd3, $urandom, 60, 55);
      run_phase(32'd0, $urandom, 20, 50);
      run_phase(32'd2, 32'd0, 50, 50);
      run_phase(32'd200, $urandom, 80, 70);
      // Only the low nine bits of the count are kept.
      run_phase(32'hA5A5_A1FF, $urandom, 60, 60);
      run_phase(32'd257, $urandom, 40, 50);

      drain();
      repeat (20) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
